>>> rtl/tbp_pkg.sv
// Shared sizes, types and counter update functions of the tournament branch predictor.
package tbp_pkg;

	// Table geometry.
	localparam int LOCAL_ENTRIES    = 1024;
	localparam int LOCAL_HIST_BITS  = 9;
	localparam int GLOBAL_HIST_BITS = 9;
	localparam int LOCAL_CTR_BITS   = 2;
	localparam int GLOBAL_CTR_BITS  = 3;
	localparam int META_CTR_BITS    = 2;
	localparam int ADDR_W           = 10;

	localparam int SLOT_W      = $clog2(LOCAL_ENTRIES);
	localparam int LPHT_DEPTH  = 1 << LOCAL_HIST_BITS;
	localparam int GPHT_DEPTH  = 1 << GLOBAL_HIST_BITS;

	// The clearing pass after reset covers the deepest table.
	localparam int CLR_DEPTH_A = (LOCAL_ENTRIES > LPHT_DEPTH) ? LOCAL_ENTRIES : LPHT_DEPTH;
	localparam int CLR_DEPTH   = (CLR_DEPTH_A > GPHT_DEPTH) ? CLR_DEPTH_A : GPHT_DEPTH;
	localparam int CLR_W       = $clog2(CLR_DEPTH);

	typedef logic [ADDR_W-1:0]           addr_t;
	typedef logic [SLOT_W-1:0]           slot_t;
	typedef logic [LOCAL_HIST_BITS-1:0]  lhist_t;
	typedef logic [GLOBAL_HIST_BITS-1:0] ghist_t;
	typedef logic [LOCAL_CTR_BITS-1:0]   lctr_t;
	typedef logic [GLOBAL_CTR_BITS-1:0]  gctr_t;
	typedef logic [META_CTR_BITS-1:0]    mctr_t;
	typedef logic [CLR_W-1:0]            clr_idx_t;

	// Branch address to local history slot, wrapping at the table size.
	function automatic slot_t slot_of(input addr_t addr);
		logic [31:0] wide;
		wide = 32'(addr);
		return slot_t'(wide % LOCAL_ENTRIES);
	endfunction

	// Saturating up/down counters, one per table.
	function automatic lctr_t lctr_move(input lctr_t c, input logic up);
		if (up) begin
			return (c == '1) ? c : lctr_t'(c + 1'b1);
		end
		return (c == '0) ? c : lctr_t'(c - 1'b1);
	endfunction

	function automatic gctr_t gctr_move(input gctr_t c, input logic up);
		if (up) begin
			return (c == '1) ? c : gctr_t'(c + 1'b1);
		end
		return (c == '0) ? c : gctr_t'(c - 1'b1);
	endfunction

	function automatic mctr_t mctr_move(input mctr_t c, input logic up);
		if (up) begin
			return (c == '1) ? c : mctr_t'(c + 1'b1);
		end
		return (c == '0) ? c : mctr_t'(c - 1'b1);
	endfunction

endpackage

>>> rtl/tbp_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module tbp_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port returns the old contents on a same-cycle write.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/tournament_branch_predictor_unit.sv
// Top level of the tournament (local/global) branch predictor.
//
// The input channel carries one resolved conditional branch per beat: the low
// address bits and the actual outcome. The output channel carries one result
// beat per input beat, in order: both component predictions, the choice of the
// meta counter, the final prediction and whether it mispredicted. Predictions
// are those made before the branch trains the tables.
// One beat is accepted every cycle while in_ready is high. The local history
// table is read at acceptance, the three counter tables as the branch enters
// stage 2, and then the output register takes the result. Updates still in
// flight are forwarded into younger branches.
// After reset the block runs a clearing pass over the deepest table (the local
// history table, 1024 entries) that zeroes all tables; in_ready stays low
// meanwhile.
// When a result waits and the receiver holds out_ready low, the whole pipeline
// holds and in_ready falls; nothing is lost or repeated.
module tournament_branch_predictor_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tbp_pkg::addr_t        branch_address_low,
	input  logic                  taken,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  final_prediction,
	output logic                  mispredicted,
	output logic                  chose_global,
	output logic                  local_prediction,
	output logic                  global_prediction
);

	// Clearing pass state.
	logic              clr_busy_q;
	tbp_pkg::clr_idx_t clr_idx_q;

	// Handshake and global history.
	logic            adv;
	logic            acc;
	tbp_pkg::ghist_t ghist_q;

	// Stage 1.
	logic            v_s1;
	tbp_pkg::slot_t  slot_s1;
	logic            tk_s1;
	tbp_pkg::ghist_t gh_s1;
	tbp_pkg::lhist_t lht_rd;
	tbp_pkg::lhist_t lh_fwd;
	tbp_pkg::lhist_t lh_next;

	// Stage 2.
	logic            v_s2;
	tbp_pkg::slot_t  slot_s2;
	logic            tk_s2;
	tbp_pkg::ghist_t gh_s2;
	tbp_pkg::lhist_t lh_s2;
	tbp_pkg::lhist_t lh_next_s2;
	tbp_pkg::lctr_t  lct_rd;
	tbp_pkg::gctr_t  gct_rd;
	tbp_pkg::mctr_t  mct_rd;
	tbp_pkg::lctr_t  lctr;
	tbp_pkg::gctr_t  gctr;
	tbp_pkg::mctr_t  mctr;
	logic            lpred;
	logic            gpred;
	logic            use_g;
	logic            fpred;
	tbp_pkg::lctr_t  lctr_next;
	tbp_pkg::gctr_t  gctr_next;
	tbp_pkg::mctr_t  mctr_next;

	// Output register, also the source of forwarded counter updates.
	logic            v_q;
	tbp_pkg::lhist_t lh_q;
	tbp_pkg::ghist_t gh_q;
	tbp_pkg::lctr_t  lctr_q;
	tbp_pkg::gctr_t  gctr_q;
	tbp_pkg::mctr_t  mctr_q;
	logic            fpred_q;
	logic            mis_q;
	logic            use_g_q;
	logic            lpred_q;
	logic            gpred_q;

	// Table write ports.
	logic            lht_we;
	tbp_pkg::slot_t  lht_wa;
	tbp_pkg::lhist_t lht_wd;
	logic            pht_we;
	tbp_pkg::lhist_t lct_wa;
	tbp_pkg::lctr_t  lct_wd;
	tbp_pkg::ghist_t gct_wa;
	tbp_pkg::gctr_t  gct_wd;
	tbp_pkg::mctr_t  mct_wd;

	// The pipeline moves as a whole whenever the output register can take a beat.
	assign adv      = !v_q || out_ready;
	assign in_ready = !clr_busy_q && adv;
	assign acc      = in_valid && in_ready;

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= tbp_pkg::clr_idx_t'(clr_idx_q + 1'b1);
			if (clr_idx_q == tbp_pkg::clr_idx_t'(tbp_pkg::CLR_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Global history shifts at acceptance, so each branch reads the history it sees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghist_q <= '0;
		end else if (acc) begin
			ghist_q <= {ghist_q[tbp_pkg::GLOBAL_HIST_BITS-2:0], taken};
		end
	end

	// Local history table: read at acceptance, written from stage 1.
	tbp_ram #(
		.DEPTH (tbp_pkg::LOCAL_ENTRIES),
		.WIDTH (tbp_pkg::LOCAL_HIST_BITS)
	) u_lht (
		.clk     (clk),
		.wr_en   (lht_we),
		.wr_addr (lht_wa),
		.wr_data (lht_wd),
		.rd_en   (acc),
		.rd_addr (tbp_pkg::slot_of(branch_address_low)),
		.rd_data (lht_rd)
	);

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			slot_s1 <= tbp_pkg::slot_of(branch_address_low);
			tk_s1   <= taken;
			gh_s1   <= ghist_q;
		end
	end

	// The branch one stage ahead wrote its slot in the cycle this one was read.
	always_comb begin
		lh_fwd  = (v_s2 && slot_s2 == slot_s1) ? lh_next_s2 : lht_rd;
		lh_next = {lh_fwd[tbp_pkg::LOCAL_HIST_BITS-2:0], tk_s1};
	end

	always_comb begin
		if (clr_busy_q) begin
			lht_we = 1'b1;
			lht_wa = clr_idx_q[tbp_pkg::SLOT_W-1:0];
			lht_wd = '0;
		end else begin
			lht_we = adv && v_s1;
			lht_wa = slot_s1;
			lht_wd = lh_next;
		end
	end

	// Counter tables: read as a branch leaves stage 1, written as it leaves stage 2.
	tbp_ram #(
		.DEPTH (tbp_pkg::LPHT_DEPTH),
		.WIDTH (tbp_pkg::LOCAL_CTR_BITS)
	) u_lct (
		.clk     (clk),
		.wr_en   (pht_we),
		.wr_addr (lct_wa),
		.wr_data (lct_wd),
		.rd_en   (adv && v_s1),
		.rd_addr (lh_fwd),
		.rd_data (lct_rd)
	);

	tbp_ram #(
		.DEPTH (tbp_pkg::GPHT_DEPTH),
		.WIDTH (tbp_pkg::GLOBAL_CTR_BITS)
	) u_gct (
		.clk     (clk),
		.wr_en   (pht_we),
		.wr_addr (gct_wa),
		.wr_data (gct_wd),
		.rd_en   (adv && v_s1),
		.rd_addr (gh_s1),
		.rd_data (gct_rd)
	);

	tbp_ram #(
		.DEPTH (tbp_pkg::GPHT_DEPTH),
		.WIDTH (tbp_pkg::META_CTR_BITS)
	) u_mct (
		.clk     (clk),
		.wr_en   (pht_we),
		.wr_addr (gct_wa),
		.wr_data (mct_wd),
		.rd_en   (adv && v_s1),
		.rd_addr (gh_s1),
		.rd_data (mct_rd)
	);

	// Stage 2 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			slot_s2    <= slot_s1;
			tk_s2      <= tk_s1;
			gh_s2      <= gh_s1;
			lh_s2      <= lh_fwd;
			lh_next_s2 <= lh_next;
		end
	end

	// Predictions and training; the branch in the output register wrote its
	// counters in the cycle this one was read, so its values take precedence.
	always_comb begin
		lctr  = (v_q && lh_q == lh_s2) ? lctr_q : lct_rd;
		gctr  = (v_q && gh_q == gh_s2) ? gctr_q : gct_rd;
		mctr  = (v_q && gh_q == gh_s2) ? mctr_q : mct_rd;
		lpred = lctr[tbp_pkg::LOCAL_CTR_BITS-1];
		gpred = gctr[tbp_pkg::GLOBAL_CTR_BITS-1];
		use_g = mctr[tbp_pkg::META_CTR_BITS-1];
		fpred = use_g ? gpred : lpred;

		lctr_next = tbp_pkg::lctr_move(lctr, tk_s2);
		gctr_next = tbp_pkg::gctr_move(gctr, tk_s2);
		if (gpred == tk_s2 && lpred != tk_s2) begin
			mctr_next = tbp_pkg::mctr_move(mctr, 1'b1);
		end else if (lpred == tk_s2 && gpred != tk_s2) begin
			mctr_next = tbp_pkg::mctr_move(mctr, 1'b0);
		end else begin
			mctr_next = mctr;
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			pht_we = 1'b1;
			lct_wa = clr_idx_q[tbp_pkg::LOCAL_HIST_BITS-1:0];
			gct_wa = clr_idx_q[tbp_pkg::GLOBAL_HIST_BITS-1:0];
			lct_wd = '0;
			gct_wd = '0;
			mct_wd = '0;
		end else begin
			pht_we = adv && v_s2;
			lct_wa = lh_s2;
			gct_wa = gh_s2;
			lct_wd = lctr_next;
			gct_wd = gctr_next;
			mct_wd = mctr_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			lh_q    <= lh_s2;
			gh_q    <= gh_s2;
			lctr_q  <= lctr_next;
			gctr_q  <= gctr_next;
			mctr_q  <= mctr_next;
			fpred_q <= fpred;
			mis_q   <= fpred ^ tk_s2;
			use_g_q <= use_g;
			lpred_q <= lpred;
			gpred_q <= gpred;
		end
	end

	assign out_valid         = v_q;
	assign final_prediction  = fpred_q;
	assign mispredicted      = mis_q;
	assign chose_global      = use_g_q;
	assign local_prediction  = lpred_q;
	assign global_prediction = gpred_q;

endmodule

>>> tb/tournament_branch_predictor_unit_tb.sv
// Self-checking testbench for the tournament branch predictor unit.
module tournament_branch_predictor_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 550;
	// Cycles without any accepted beat before the run is declared hung. This
	// covers the clearing pass after reset several times over.
	localparam int STALL_LIMIT  = 6000;
	localparam int DRAIN_CYCLES = 8;

	// One predicted result beat.
	typedef struct packed {
		logic final_pred;
		logic miss;
		logic chose_glob;
		logic local_pred;
		logic global_pred;
	} verdict_t;

	// Tracks the predictor tables and the queue of expected result beats.
	class branch_book;
		tbp_pkg::lhist_t local_hist [tbp_pkg::LOCAL_ENTRIES];
		tbp_pkg::lctr_t  local_ctr  [tbp_pkg::LPHT_DEPTH];
		tbp_pkg::gctr_t  global_ctr [tbp_pkg::GPHT_DEPTH];
		tbp_pkg::mctr_t  meta_ctr   [tbp_pkg::GPHT_DEPTH];
		tbp_pkg::ghist_t ghist;
		verdict_t        verdicts [$];
		int              mismatches;

		function new();
			foreach (local_hist[i]) local_hist[i] = '0;
			foreach (local_ctr[i]) local_ctr[i] = '0;
			foreach (global_ctr[i]) global_ctr[i] = '0;
			foreach (meta_ctr[i]) meta_ctr[i] = '0;
			ghist = '0;
			mismatches = 0;
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		// Predict the result of one accepted branch, then train every table.
		function void note_branch(tbp_pkg::addr_t addr, logic tk);
			tbp_pkg::slot_t  slot;
			tbp_pkg::lhist_t lh;
			tbp_pkg::ghist_t gh;
			tbp_pkg::lctr_t  lc;
			tbp_pkg::gctr_t  gc;
			tbp_pkg::mctr_t  mc;
			verdict_t        v;
			slot = tbp_pkg::slot_t'(int'(addr) % tbp_pkg::LOCAL_ENTRIES);
			lh = local_hist[slot];
			gh = ghist;
			lc = local_ctr[lh];
			gc = global_ctr[gh];
			mc = meta_ctr[gh];

			// A counter predicts taken when it sits in the upper half of its range.
			v.local_pred  = lc[tbp_pkg::LOCAL_CTR_BITS-1];
			v.global_pred = gc[tbp_pkg::GLOBAL_CTR_BITS-1];
			v.chose_glob  = mc[tbp_pkg::META_CTR_BITS-1];
			v.final_pred  = v.chose_glob ? v.global_pred : v.local_pred;
			v.miss        = v.final_pred ^ tk;
			verdicts.push_back(v);

			// Saturating training of the two direction counters.
			if (tk && lc != '1) lc = lc + 1'b1;
			else if (!tk && lc != '0) lc = lc - 1'b1;
			if (tk && gc != '1) gc = gc + 1'b1;
			else if (!tk && gc != '0) gc = gc - 1'b1;
			local_ctr[lh]  = lc;
			global_ctr[gh] = gc;

			// The chooser moves only when exactly one predictor was right.
			if (v.global_pred == tk && v.local_pred != tk && mc != '1) begin
				meta_ctr[gh] = mc + 1'b1;
			end else if (v.local_pred == tk && v.global_pred != tk && mc != '0) begin
				meta_ctr[gh] = mc - 1'b1;
			end

			local_hist[slot] = {lh[tbp_pkg::LOCAL_HIST_BITS-2:0], tk};
			ghist = {gh[tbp_pkg::GLOBAL_HIST_BITS-2:0], tk};
		endfunction

		// Compare one result beat with the oldest expectation, field by field.
		function void check_result(verdict_t got);
			verdict_t want;
			string    names [5];
			names = '{"final_prediction", "mispredicted", "chose_global",
				"local_prediction", "global_prediction"};
			if (verdicts.size() == 0) begin
				if (mismatches < 10) $display("result beat with nothing expected: %b", got);
				mismatches++;
				return;
			end
			want = verdicts.pop_front();
			for (int i = 0; i < 5; i++) begin
				if (want[4-i] !== got[4-i]) begin
					if (mismatches < 10) begin
						$display("%s mismatch: expected %b, got %b", names[i],
							want[4-i], got[4-i]);
					end
					mismatches++;
				end
			end
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	tbp_pkg::addr_t branch_address_low = '0;
	logic           taken = 1'b0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	logic           final_prediction;
	logic           mispredicted;
	logic           chose_global;
	logic           local_prediction;
	logic           global_prediction;

	branch_book book = new();
	int         send_burst = 0;
	int         recv_burst = 0;
	int         quiet_cycles = 0;

	tournament_branch_predictor_unit uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.branch_address_low (branch_address_low),
		.taken              (taken),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.final_prediction   (final_prediction),
		.mispredicted       (mispredicted),
		.chose_global       (chose_global),
		.local_prediction   (local_prediction),
		.global_prediction  (global_prediction)
	);

	always #4 clk = ~clk;

	// Idle gap before a beat: drawn at random, none during a burst.
	function automatic int draw_gap(ref int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) burst = $urandom_range(10, 40);
		return $urandom_range(0, 10);
	endfunction

	// Offer one branch beat and hold it until the block takes it.
	task automatic send_branch(tbp_pkg::addr_t addr, logic tk);
		int gap;
		gap = draw_gap(send_burst);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		branch_address_low <= addr;
		taken <= tk;
		do @(posedge clk); while (!in_ready);
		book.note_branch(addr, tk);
	endtask

	task automatic wait_all_results();
		while (book.pending() != 0) @(posedge clk);
	endtask

	// Stimulus: directed corners first, then loop-like and patterned branches.
	initial begin : stimulus
		tbp_pkg::addr_t pool [8];
		tbp_pkg::addr_t a;
		int    done;
		int    kind;
		int    trips;
		int    reps;
		logic [3:0] pattern;
		bit    paused;
		done = 0;
		paused = 0;
		foreach (pool[i]) pool[i] = tbp_pkg::addr_t'($urandom_range(0, 1023));

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Address extremes, alternating bit patterns, then long runs that drive
		// counters toward saturation at both ends.
		send_branch(10'd0, 1'b0);
		send_branch(10'd1023, 1'b1);
		send_branch(10'h155, 1'b1);
		send_branch(10'h2AA, 1'b0);
		repeat (10) send_branch(10'd1023, 1'b1);
		repeat (8) send_branch(10'd0, 1'b0);
		send_branch(10'h2AA, 1'b1);
		send_branch(10'h155, 1'b0);

		while (done < RANDOM_ITEMS) begin
			// Halfway through, let the pipeline run dry before sending more.
			if (!paused && done >= RANDOM_ITEMS / 2) begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait_all_results();
				paused = 1;
			end
			kind = $urandom_range(0, 9);
			a = pool[$urandom_range(0, 7)];
			if (kind <= 5) begin
				// Loop branch: taken on every trip but the last.
				trips = $urandom_range(1, 12);
				for (int i = 0; i < trips; i++) send_branch(a, i != trips - 1);
				done += trips;
			end else if (kind <= 7) begin
				// Short repeating outcome pattern on one branch.
				pattern = 4'($urandom_range(0, 15));
				reps = $urandom_range(2, 4);
				repeat (reps) begin
					for (int i = 0; i < 4; i++) send_branch(a, pattern[i]);
				end
				done += 4 * reps;
			end else begin
				// Noise: unrelated branches, and a fresh address for the pool.
				trips = $urandom_range(1, 6);
				repeat (trips) begin
					send_branch(tbp_pkg::addr_t'($urandom_range(0, 1023)),
						1'($urandom_range(0, 1)));
				end
				pool[$urandom_range(0, 7)] = tbp_pkg::addr_t'($urandom_range(0, 1023));
				done += trips;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.mismatches == 0 && book.pending() == 0) begin
			$display("tournament_branch_predictor_unit_tb: clean");
		end else begin
			$display("tournament_branch_predictor_unit_tb: errors");
		end
		$finish;
	end

	// Receiver: stalls at random, checks every accepted result beat.
	initial begin : receiver
		int gap;
		forever begin
			gap = draw_gap(recv_burst);
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && arst_n));
			book.check_result({final_prediction, mispredicted, chose_global,
				local_prediction, global_prediction});
		end
	end

	// Watchdog: ends the run when no beat moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tournament_branch_predictor_unit_tb: errors");
			$finish;
		end
	end

endmodule
